FILE: design/dt2fp_pkg.sv
`default_nettype none

package dt2fp_pkg;

	// Fixed widths of the accumulators carried between the parts
	localparam int FRAC_ACC_W = 30;   // holds up to nine decimal fraction digits
	localparam int INT_ACC_W  = 31;   // widest integer part the block supports

	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_POINT = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;

	localparam logic [3:0] MAX_FRAC_RESET = 4'd5;
	localparam logic [3:0] FRAC_CAP       = 4'd9;
	localparam logic [1:0] LAST_COMP      = 2'd2;

	typedef enum logic [2:0] {
		PH_IDLE  = 3'd0,
		PH_LEAD  = 3'd1,
		PH_MINUS = 3'd2,
		PH_INT   = 3'd3,
		PH_POINT = 3'd4,
		PH_FRAC  = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FORMAT = 2'd1,
		ST_DIGITS = 2'd2
	} status_t;

	// One finished number (or an error) handed from the parser to the converter
	typedef struct packed {
		status_t                 status;
		logic [1:0]              comp;
		logic                    neg;
		logic                    consumed;
		logic [INT_ACC_W-1:0]    int_acc;
		logic [FRAC_ACC_W-1:0]   frac_acc;
		logic [3:0]              frac_cnt;
	} token_t;

	// Fields that ride along the converter pipeline
	typedef struct packed {
		status_t                 status;
		logic [1:0]              comp;
		logic                    neg;
		logic                    consumed;
		logic [INT_ACC_W-1:0]    int_acc;
	} meta_t;

	function automatic logic [FRAC_ACC_W-1:0] pow10(input logic [3:0] k);
		logic [FRAC_ACC_W-1:0] r;
		case (k)
			4'd0: r = 30'd1;
			4'd1: r = 30'd10;
			4'd2: r = 30'd100;
			4'd3: r = 30'd1000;
			4'd4: r = 30'd10000;
			4'd5: r = 30'd100000;
			4'd6: r = 30'd1000000;
			4'd7: r = 30'd10000000;
			4'd8: r = 30'd100000000;
			4'd9: r = 30'd1000000000;
			default: r = 30'd1;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: design/dt2fp_in_if.sv
`default_nettype none

interface dt2fp_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       start_req;

	modport source (output valid, output ch, output start_req, input ready);
	modport sink   (input valid, input ch, input start_req, output ready);
endinterface

`default_nettype wire

FILE: design/dt2fp_out_if.sv
`default_nettype none

interface dt2fp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] x_value;
	logic signed [31:0] y_value;
	logic signed [31:0] z_value;
	logic [1:0]         status;
	logic               byte_consumed;

	modport source (output valid, output x_value, output y_value, output z_value,
		output status, output byte_consumed, input ready);
	modport sink   (input valid, input x_value, input y_value, input z_value,
		input status, input byte_consumed, output ready);
endinterface

`default_nettype wire

FILE: design/dt2fp_front.sv
`default_nettype none

module dt2fp_front
	import dt2fp_pkg::*;
#(
	parameter int INT_BITS = 15
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	dt2fp_in_if.sink    text,
	input  wire logic   cfg_we,
	input  wire logic [3:0] cfg_wdata,
	input  wire logic   q_full,
	output logic        push,
	output token_t      tok
);

	localparam logic [INT_BITS+3:0] INT_MAX = {4'b0, {INT_BITS{1'b1}}};

	phase_t                 phase_q, phase_d;
	logic [1:0]             comp_q, comp_d;
	logic                   neg_q, neg_d;
	logic [INT_ACC_W-1:0]   int_q, int_d;
	logic [FRAC_ACC_W-1:0]  frac_q, frac_d;
	logic [3:0]             cnt_q, cnt_d;
	logic [3:0]             max_frac_q;

	logic                   acc, start;
	logic                   is_digit, is_minus, is_point, is_comma;
	logic [3:0]             dgt, lim;
	phase_t                 cur_ph;
	logic [1:0]             cur_comp;
	logic                   cur_neg;
	logic [INT_ACC_W-1:0]   cur_int;
	logic [FRAC_ACC_W-1:0]  cur_frac;
	logic [3:0]             cur_cnt;
	logic [INT_BITS+3:0]    int_x10, int_sat;
	logic [FRAC_ACC_W+3:0]  frac_x10;
	logic                   ends_fail, frac_over;
	phase_t                 end_next;

	assign text.ready = !q_full;
	assign acc        = text.valid && text.ready;
	assign start      = text.start_req;

	assign is_digit = text.ch inside {[CH_ZERO:CH_NINE]};
	assign is_minus = (text.ch == CH_MINUS);
	assign is_point = (text.ch == CH_POINT);
	assign is_comma = (text.ch == CH_COMMA);
	assign dgt      = is_digit ? text.ch[3:0] : 4'd0;
	assign lim      = (max_frac_q > FRAC_CAP) ? FRAC_CAP : max_frac_q;

	// a start byte wipes any half-parsed triple before it is looked at
	assign cur_ph   = start ? PH_LEAD : phase_q;
	assign cur_comp = start ? 2'd0 : comp_q;
	assign cur_neg  = start ? 1'b0 : neg_q;
	assign cur_int  = start ? '0 : int_q;
	assign cur_frac = start ? '0 : frac_q;
	assign cur_cnt  = start ? 4'd0 : cnt_q;

	assign int_x10 = ({4'b0, cur_int[INT_BITS-1:0]} << 3)
		+ ({4'b0, cur_int[INT_BITS-1:0]} << 1) + (INT_BITS+4)'(dgt);
	assign int_sat = (int_x10 > INT_MAX) ? INT_MAX : int_x10;
	assign frac_x10 = ({4'b0, cur_frac} << 3) + ({4'b0, cur_frac} << 1)
		+ (FRAC_ACC_W+4)'(dgt);

	assign frac_over = (cur_cnt >= lim);
	assign ends_fail = !is_comma && (cur_comp != LAST_COMP);
	assign end_next  = (is_comma && cur_comp != LAST_COMP) ? PH_LEAD : PH_IDLE;

	// next state
	always_comb begin
		phase_d = phase_q;
		if (acc) begin
			case (cur_ph)
				PH_LEAD: begin
					if (is_minus)
						phase_d = PH_MINUS;
					else if (is_digit)
						phase_d = PH_INT;
					else
						phase_d = PH_IDLE;
				end
				PH_MINUS: phase_d = is_digit ? PH_INT : PH_IDLE;
				PH_INT: begin
					if (is_digit)
						phase_d = PH_INT;
					else if (is_point)
						phase_d = PH_POINT;
					else
						phase_d = end_next;
				end
				PH_POINT, PH_FRAC: begin
					if (is_digit)
						phase_d = frac_over ? PH_IDLE : PH_FRAC;
					else if (cur_ph == PH_POINT)
						phase_d = PH_IDLE;
					else
						phase_d = end_next;
				end
				default: phase_d = PH_IDLE;
			endcase
		end
	end

	// accumulators and token push
	always_comb begin
		push         = 1'b0;
		tok.status   = ST_OK;
		tok.comp     = cur_comp;
		tok.neg      = cur_neg;
		tok.consumed = is_comma;
		tok.int_acc  = cur_int;
		tok.frac_acc = cur_frac;
		tok.frac_cnt = cur_cnt;
		comp_d = comp_q;
		neg_d  = neg_q;
		int_d  = int_q;
		frac_d = frac_q;
		cnt_d  = cnt_q;
		if (acc) begin
			comp_d = cur_comp;
			neg_d  = cur_neg;
			int_d  = cur_int;
			frac_d = cur_frac;
			cnt_d  = cur_cnt;
			case (cur_ph)
				PH_LEAD, PH_MINUS: begin
					if (cur_ph == PH_LEAD && is_minus) begin
						neg_d = 1'b1;
					end else if (is_digit) begin
						int_d = INT_ACC_W'(dgt);
					end else begin
						push       = 1'b1;
						tok.status = ST_FORMAT;
					end
				end
				PH_INT, PH_POINT, PH_FRAC: begin
					if (is_digit && cur_ph == PH_INT) begin
						int_d = INT_ACC_W'(int_sat);
					end else if (is_digit) begin
						if (frac_over) begin
							push       = 1'b1;
							tok.status = ST_DIGITS;
						end else begin
							frac_d = frac_x10[FRAC_ACC_W-1:0];
							cnt_d  = cur_cnt + 4'd1;
						end
					end else if (is_point && cur_ph == PH_INT) begin
						// nothing to store, the phase moves on
					end else if (cur_ph == PH_POINT || ends_fail) begin
						push       = 1'b1;
						tok.status = ST_FORMAT;
					end else begin
						push = 1'b1;
						if (cur_comp != LAST_COMP) begin
							comp_d = cur_comp + 2'd1;
							neg_d  = 1'b0;
							int_d  = '0;
							frac_d = '0;
							cnt_d  = 4'd0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			comp_q     <= 2'd0;
			neg_q      <= 1'b0;
			int_q      <= '0;
			frac_q     <= '0;
			cnt_q      <= 4'd0;
			max_frac_q <= MAX_FRAC_RESET;
		end else begin
			phase_q <= phase_d;
			comp_q  <= comp_d;
			neg_q   <= neg_d;
			int_q   <= int_d;
			frac_q  <= frac_d;
			cnt_q   <= cnt_d;
			if (cfg_we)
				max_frac_q <= cfg_wdata;
		end
	end

	a_ok_token_sane: assert property (@(posedge clk) disable iff (!arst_n)
		(push && tok.status == ST_OK) |-> (tok.frac_cnt <= FRAC_CAP && tok.comp <= LAST_COMP))
		else $error("good token with bad digit count or component");

endmodule

`default_nettype wire

FILE: design/dt2fp_queue.sv
`default_nettype none

module dt2fp_queue
	import dt2fp_pkg::*;
#(
	parameter int DEPTH = 4
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  token_t    push_tok,
	output logic      full,
	input  wire logic pop,
	output logic      avail,
	output token_t    head
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	token_t         mem_q [DEPTH];
	logic [PW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]  count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign avail = (count_q != '0);
	assign head  = mem_q[rd_ptr_q];

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_tok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= bump(wr_ptr_q);
			if (pop)
				rd_ptr_q <= bump(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + CW'(1);
			else if (pop && !push)
				count_q <= count_q - CW'(1);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> !push)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!avail |-> !pop)
		else $error("pop from empty queue");

endmodule

`default_nettype wire

FILE: design/dt2fp_back.sv
`default_nettype none

module dt2fp_back
	import dt2fp_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS  = 15
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  avail,
	input  token_t     head,
	output logic       pop,
	dt2fp_out_if.source result
);

	localparam int NW     = FRAC_ACC_W + FRAC_BITS + 1;
	localparam int QW     = FRAC_BITS + 1;
	localparam int MW     = INT_BITS + FRAC_BITS + 1;
	localparam int STAGES = FRAC_BITS + 1;
	localparam int LAST   = STAGES + 2;
	localparam logic [MW-1:0] LIMIT = (INT_BITS + FRAC_BITS >= 31) ?
		MW'(64'h7FFF_FFFF) : MW'((64'd1 << (INT_BITS + FRAC_BITS)) - 64'd1);

	logic                   adv;
	logic                   vld_s  [0:LAST];
	meta_t                  meta_s [0:LAST];
	logic [NW-1:0]          rem_s  [0:STAGES];
	logic [FRAC_ACC_W-1:0]  dvs_s  [0:STAGES];
	logic [QW-1:0]          q_s    [0:STAGES];
	logic [MW-1:0]          mag_s;
	logic [31:0]            val_s;
	logic [MW-1:0]          mag_sat;
	logic [31:0]            mag_32;
	logic [FRAC_ACC_W-1:0]  dvs_in;
	logic                   emit;

	logic                   out_valid_q;
	logic [31:0]            x_q, y_q, z_q;
	status_t                status_q;
	logic                   consumed_q;
	logic [31:0]            saved_x_q, saved_y_q;

	// whole pipeline moves together; it only holds while a result waits
	assign adv    = !out_valid_q || result.ready;
	assign pop    = adv && avail;
	assign dvs_in = pow10(head.frac_cnt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= pop;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s[0] <= '{status: head.status, comp: head.comp, neg: head.neg,
				consumed: head.consumed, int_acc: head.int_acc};
			rem_s[0]  <= (NW'(head.frac_acc) << FRAC_BITS) + NW'(dvs_in >> 1);
			dvs_s[0]  <= dvs_in;
			q_s[0]    <= '0;
		end
	end

	// restoring division, one quotient bit per stage, top bit first
	for (genvar j = 0; j < STAGES; j++) begin : g_div
		localparam int SH = FRAC_BITS - j;
		logic [NW-1:0] dsh;
		logic          take;
		assign dsh  = NW'(dvs_s[j]) << SH;
		assign take = (rem_s[j] >= dsh);
		always_ff @(posedge clk) begin
			if (adv) begin
				rem_s[j+1] <= take ? rem_s[j] - dsh : rem_s[j];
				dvs_s[j+1] <= dvs_s[j];
				q_s[j+1]   <= q_s[j] | (QW'(take) << SH);
			end
		end
	end

	for (genvar j = 0; j < LAST; j++) begin : g_ride
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else if (adv) begin
				vld_s[j+1] <= vld_s[j];
			end
		end
		always_ff @(posedge clk) begin
			if (adv)
				meta_s[j+1] <= meta_s[j];
		end
	end

	assign mag_sat = (mag_s > LIMIT) ? LIMIT : mag_s;
	assign mag_32  = 32'(mag_sat);

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s <= MW'({meta_s[STAGES].int_acc[INT_BITS-1:0], {FRAC_BITS{1'b0}}})
				+ MW'(q_s[STAGES]);
			val_s <= meta_s[STAGES+1].neg ? 32'd0 - mag_32 : mag_32;
		end
	end

	assign emit = vld_s[LAST] &&
		(meta_s[LAST].status != ST_OK || meta_s[LAST].comp == LAST_COMP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			saved_x_q   <= '0;
			saved_y_q   <= '0;
		end else if (adv) begin
			out_valid_q <= emit;
			if (vld_s[LAST] && meta_s[LAST].status == ST_OK) begin
				if (meta_s[LAST].comp == 2'd0)
					saved_x_q <= val_s;
				else if (meta_s[LAST].comp == 2'd1)
					saved_y_q <= val_s;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && emit) begin
			status_q <= meta_s[LAST].status;
			if (meta_s[LAST].status == ST_OK) begin
				x_q        <= saved_x_q;
				y_q        <= saved_y_q;
				z_q        <= val_s;
				consumed_q <= meta_s[LAST].consumed;
			end else begin
				x_q        <= '0;
				y_q        <= '0;
				z_q        <= '0;
				consumed_q <= 1'b0;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.x_value       = x_q;
	assign result.y_value       = y_q;
	assign result.z_value       = z_q;
	assign result.status        = status_q;
	assign result.byte_consumed = consumed_q;

	a_error_zeroed: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && status_q != ST_OK)
			|-> (x_q == '0 && y_q == '0 && z_q == '0 && !consumed_q))
		else $error("error result carries data");

endmodule

`default_nettype wire

FILE: design/decimal_triple_to_fixed_point_top.sv
// Channel    Role  Handshake       Payload
// text       in    valid / ready   ch[7:0], start_req
// result     out   valid / ready   x_value, y_value, z_value [31:0] s, status[1:0],
//                                  byte_consumed
// cfg        in    cfg_we          cfg_wdata[3:0] = max_fraction_digits
//
// One byte per cycle in, sustained; text.ready drops only when the token
// queue fills behind a stalled result.
// A result passes from the byte that ends it through the token queue, entry
// stage, FRAC_BITS + 1 divider stages, add, saturate and sign, output register.
// Reset (arst_n low) clears the parser, queue and pipeline valids and sets
// max_fraction_digits to 5.
// A waiting result freezes the conversion pipeline; the parser keeps going
// until the queue is full.
`default_nettype none

module decimal_triple_to_fixed_point_top
	import dt2fp_pkg::*;
#(
	parameter int FRAC_BITS = 16,
	parameter int INT_BITS  = 15
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	dt2fp_in_if.sink        text,
	dt2fp_out_if.source     result,
	input  wire logic       cfg_we,
	input  wire logic [3:0] cfg_wdata
);

	// Front: byte parser. Accepted digits update the digit
	// accumulators; a number that ends (or an error) becomes one token.
	logic   push, q_full, q_avail, pop;
	token_t push_tok, head_tok;

	dt2fp_front #(
		.INT_BITS (INT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.text      (text),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.q_full    (q_full),
		.push      (push),
		.tok       (push_tok)
	);

	// Short queue decouples parser from converter so either side may stall
	dt2fp_queue #(
		.DEPTH (4)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_tok (push_tok),
		.full     (q_full),
		.pop      (pop),
		.avail    (q_avail),
		.head     (head_tok)
	);

	// Back: scales the decimal fraction to binary by a pipelined divide by
	// 10^digits (rounded), adds the integer part, saturates, applies sign,
	// and gathers x and y until z completes the triple; an error gives zeroed values.
	dt2fp_back #(
		.FRAC_BITS (FRAC_BITS),
		.INT_BITS  (INT_BITS)
	) u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.avail  (q_avail),
		.head   (head_tok),
		.pop    (pop),
		.result (result)
	);

endmodule

`default_nettype wire
